// File: src/collinear_point_filter_unit_defines.svh
// Assertion macros shared by the collinear point filter RTL.
`ifndef COLLINEAR_POINT_FILTER_UNIT_DEFINES_SVH
`define COLLINEAR_POINT_FILTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("collinear point filter check failed");
`define CPF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("collinear point filter check failed");
`else
`define CPF_ASSERT(lbl, prop)
`define CPF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: src/cpf_pkg.sv
// Types and constants of the collinear point filter.
`timescale 1ns / 1ps
package cpf_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned DiffBits    = CoordBits + 1;
  localparam int unsigned ProdBits    = 2 * DiffBits;
  localparam int unsigned MaxPush     = 3;
  localparam int unsigned PushBits    = 2;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrBits = 2;
  localparam int unsigned FifoCntBits = 3;

  typedef struct packed {
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic                        final_point;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] kept_x;
    logic signed [CoordBits-1:0] kept_y;
    logic                        final_kept;
  } out_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } point_t;

  typedef struct packed {
    logic [FifoCntBits-1:0] count;
    logic                   pop;
  } fifo_stat_t;

endpackage

// File: src/cpf_midtest.sv
// Redundancy test of a middle point: zero determinant and strictly between.
`timescale 1ns / 1ps
module cpf_midtest (
  input  cpf_pkg::point_t p_i,
  input  cpf_pkg::point_t q_i,
  input  cpf_pkg::point_t r_i,
  output logic            redundant_o
);

  localparam int unsigned D = cpf_pkg::DiffBits;
  localparam int unsigned P = cpf_pkg::ProdBits;
  localparam int unsigned C = cpf_pkg::CoordBits;

  function automatic logic signed [D-1:0] diff(logic signed [C-1:0] a,
                                                logic signed [C-1:0] b);
    logic signed [D-1:0] ae;
    logic signed [D-1:0] be;
    ae = $signed({a[C-1], a});
    be = $signed({b[C-1], b});
    return ae - be;
  endfunction

  function automatic logic [P-1:0] sq(logic signed [D-1:0] d);
    logic signed [P-1:0] de;
    de = $signed({{(P-D){d[D-1]}}, d});
    return $unsigned(de * de);
  endfunction

  logic signed [D-1:0] qpx, qpy, rpx, rpy, rqx, rqy;
  logic signed [P-1:0] det_a, det_b;
  logic [P:0]          d_pr, d_pq, d_qr;

  always_comb begin
    qpx = diff(q_i.x, p_i.x);
    qpy = diff(q_i.y, p_i.y);
    rpx = diff(r_i.x, p_i.x);
    rpy = diff(r_i.y, p_i.y);
    rqx = diff(r_i.x, q_i.x);
    rqy = diff(r_i.y, q_i.y);
    det_a = $signed({{(P-D){qpx[D-1]}}, qpx}) * $signed({{(P-D){rpy[D-1]}}, rpy});
    det_b = $signed({{(P-D){qpy[D-1]}}, qpy}) * $signed({{(P-D){rpx[D-1]}}, rpx});
    d_pr = {1'b0, sq(rpx)} + {1'b0, sq(rpy)};
    d_pq = {1'b0, sq(qpx)} + {1'b0, sq(qpy)};
    d_qr = {1'b0, sq(rqx)} + {1'b0, sq(rqy)};
    redundant_o = (det_a == det_b) && (d_pr > d_pq) && (d_pr > d_qr);
  end

endmodule

// File: src/cpf_outq.sv
// Output queue that takes up to three words per cycle and sends one while the output is not stalled.
`timescale 1ns / 1ps
module cpf_outq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [cpf_pkg::PushBits-1:0]       push_n_i,
  input  cpf_pkg::out_word_t                 push_w_i [cpf_pkg::MaxPush],
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cpf_pkg::out_word_t                 out_data_o,
  output cpf_pkg::fifo_stat_t                stat_o
);

  localparam int unsigned PB = cpf_pkg::FifoPtrBits;
  localparam int unsigned CB = cpf_pkg::FifoCntBits;

  cpf_pkg::out_word_t mem_q [cpf_pkg::FifoDepth];
  logic [PB-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign stat_o      = '{count: cnt_q, pop: pop};

  always_comb begin
    wr_ptr_d = wr_ptr_q + PB'(push_n_i);
    rd_ptr_d = rd_ptr_q + PB'(pop);
    cnt_d    = cnt_q + CB'(push_n_i) - CB'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < cpf_pkg::MaxPush; k++) begin
      if (k < int'(push_n_i)) begin
        mem_q[wr_ptr_q + PB'(k)] <= push_w_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: src/collinear_point_filter_unit.sv
// A point is registered at the input, decided once the output queue has room, and its words are offered from the queue.
// Throughput: one point per cycle while the output drains one word per cycle.
// A final point yields up to three words, so the next point is held while the output drains.
// The window (two held points, redundancy flag, count) and the four-word output queue
// set the rate. Asynchronous active-low reset empties the queue and clears the window.
// The window also returns to its reset state after every final point.
`timescale 1ns / 1ps
`include "collinear_point_filter_unit_defines.svh"
module collinear_point_filter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cpf_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpf_pkg::out_word_t  out_data_o
);

  localparam int unsigned NB = cpf_pkg::PushBits;

  cpf_pkg::in_word_t   in_q;
  logic                in_vld_q;
  cpf_pkg::point_t     older_q, older_d, newer_q, newer_d, cur;
  logic                prior_q, prior_d;
  logic [1:0]          seen_q, seen_d;
  logic                red, room, proc, accept;
  logic [NB-1:0]       n, push_n;
  cpf_pkg::out_word_t  w [cpf_pkg::MaxPush];
  cpf_pkg::fifo_stat_t qstat;

  // A decision pushes up to three words; the queue must hold them after this cycle's pop.
  assign room       = (qstat.count <= 3'd1) || ((qstat.count == 3'd2) && qstat.pop);
  assign proc       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign cur        = '{x: in_q.px, y: in_q.py};

  cpf_midtest u_midtest (
    .p_i        (older_q),
    .q_i        (newer_q),
    .r_i        (cur),
    .redundant_o(red)
  );

  always_comb begin
    n       = '0;
    older_d = older_q;
    newer_d = newer_q;
    prior_d = prior_q;
    seen_d  = seen_q;
    for (int k = 0; k < cpf_pkg::MaxPush; k++) begin
      w[k] = '0;
    end
    if (seen_q == 2'd2) begin
      // The older point goes unless it and the newer point are both redundant.
      if (!(red && prior_q)) begin
        w[n] = '{kept_x: older_q.x, kept_y: older_q.y, final_kept: 1'b0};
        n    = n + NB'(1);
      end
      prior_d = red;
      older_d = newer_q;
      newer_d = cur;
      if (in_q.final_point) begin
        w[n] = '{kept_x: newer_q.x, kept_y: newer_q.y, final_kept: 1'b0};
        n    = n + NB'(1);
        w[n] = '{kept_x: cur.x, kept_y: cur.y, final_kept: 1'b1};
        n    = n + NB'(1);
      end
    end else if (in_q.final_point) begin
      if (seen_q == 2'd1) begin
        w[n] = '{kept_x: newer_q.x, kept_y: newer_q.y, final_kept: 1'b0};
        n    = n + NB'(1);
      end
      w[n] = '{kept_x: cur.x, kept_y: cur.y, final_kept: 1'b1};
      n    = n + NB'(1);
    end else begin
      older_d = newer_q;
      newer_d = cur;
      seen_d  = seen_q + 2'd1;
    end
    if (in_q.final_point) begin
      older_d = '0;
      newer_d = '0;
      prior_d = 1'b0;
      seen_d  = '0;
    end
    push_n = proc ? n : '0;
  end

  cpf_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .push_w_i   (w),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .stat_o     (qstat)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      older_q  <= '0;
      newer_q  <= '0;
      prior_q  <= 1'b0;
      seen_q   <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc) begin
        older_q <= older_d;
        newer_q <= newer_d;
        prior_q <= prior_d;
        seen_q  <= seen_d;
      end
    end
  end

  `CPF_ASSERT_ALWAYS(a_queue_bound, !rst_ni || (qstat.count <= 3'd4))
  `CPF_ASSERT_ALWAYS(a_seen_sat, !rst_ni || (seen_q != 2'd3))
  `CPF_ASSERT(a_push_shows, (proc && (push_n != '0)) |=> out_valid_o)
  `CPF_ASSERT(a_final_clears, (proc && in_q.final_point) |=> (seen_q == 2'd0) && !prior_q)

endmodule
